// File: rtl/r2h_pkg.sv
// Shared widths, constants and the front-to-back item type of the RGB to HSL converter.
package r2h_pkg;

	localparam int CHANNEL_BITS  = 8;
	localparam int FRACTION_BITS = 16;

	localparam int SUM_W  = CHANNEL_BITS + 1;
	localparam int SIX_W  = CHANNEL_BITS + 3;
	localparam int POS_W  = CHANNEL_BITS + 4;
	localparam int IN_W   = ((3 * CHANNEL_BITS + 7) / 8) * 8;
	localparam int RES_W  = 2 * FRACTION_BITS + SUM_W;
	localparam int OUT_W  = ((RES_W + 7) / 8) * 8;

	// Work handed from the classifier to the divider pipeline.
	typedef struct packed {
		logic [SIX_W-1:0]        hue_num;
		logic [SIX_W-1:0]        six;
		logic [CHANNEL_BITS-1:0] delta;
		logic [CHANNEL_BITS-1:0] den;
		logic                    sat_full;
		logic [SUM_W-1:0]        sum;
		logic                    gray;
	} r2h_item_t;

endpackage

// File: rtl/r2h_front.sv
// Front stage: finds max and min, and prepares the hue and saturation divisions.
module r2h_front import r2h_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [CHANNEL_BITS-1:0] red,
	input  logic [CHANNEL_BITS-1:0] green,
	input  logic [CHANNEL_BITS-1:0] blue,
	output logic                    out_valid,
	input  logic                    out_ready,
	output r2h_item_t               out_item
);

	localparam logic [SUM_W-1:0] FULL     = SUM_W'((1 << CHANNEL_BITS) - 1);
	localparam logic [SUM_W-1:0] TWO_FULL = SUM_W'(2 * ((1 << CHANNEL_BITS) - 1));

	logic [CHANNEL_BITS-1:0] mx, mn, delta;
	logic [SUM_W-1:0]        sum, den_w;
	logic [POS_W-1:0]        pos, neg, six_w, num_w;
	logic                    r_max, g_max;
	r2h_item_t               item;
	logic                    v_s1;
	r2h_item_t               item_s1;

	// Channel extremes, delta, sum and the division operands.
	always_comb begin
		r_max = (red >= green) && (red >= blue);
		g_max = !r_max && (green >= blue);
		mx    = r_max ? red : (g_max ? green : blue);
		mn    = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		delta = mx - mn;
		sum   = {1'b0, mx} + {1'b0, mn};
		den_w = (sum <= FULL) ? sum : (TWO_FULL - sum);
		six_w = (POS_W'(delta) << 2) + (POS_W'(delta) << 1);
		if (r_max) begin
			pos = POS_W'(green);
			neg = POS_W'(blue);
		end else if (g_max) begin
			pos = (POS_W'(delta) << 1) + POS_W'(blue);
			neg = POS_W'(red);
		end else begin
			pos = (POS_W'(delta) << 2) + POS_W'(red);
			neg = POS_W'(green);
		end
		if (pos < neg) pos = pos + six_w;
		num_w = pos - neg;
		item.hue_num  = num_w[SIX_W-1:0];
		item.six      = six_w[SIX_W-1:0];
		item.delta    = delta;
		item.den      = den_w[CHANNEL_BITS-1:0];
		item.sat_full = (SUM_W'(delta) == den_w);
		item.sum      = sum;
		item.gray     = (delta == '0);
	end

	assign in_ready  = !v_s1 || out_ready;
	assign out_valid = v_s1;
	assign out_item  = item_s1;

	// Stage register in front of the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item;
		end
	end

endmodule

// File: rtl/r2h_fifo.sv
// Two-entry queue that decouples the front stage from the divider pipeline.
module r2h_fifo import r2h_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  r2h_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output r2h_item_t out_item
);

	r2h_item_t  mem [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_item  = mem[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= in_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && count_q == 2'd1) |=> count_q == 2'd2)
		else $error("queue did not fill");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push && count_q == 2'd1) |=> !out_valid)
		else $error("queue did not drain");

endmodule

// File: rtl/r2h_back.sv
// Back part: pipelined restoring dividers for hue and saturation, one quotient bit per stage.
module r2h_back import r2h_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  r2h_item_t                in_item,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [FRACTION_BITS-1:0] hue,
	output logic [FRACTION_BITS-1:0] saturation,
	output logic [SUM_W-1:0]         lightness_sum,
	output logic                     achromatic
);

	localparam int F = FRACTION_BITS;
	localparam int CB = CHANNEL_BITS;

	logic                    v_q    [1:F];
	logic [SIX_W-1:0]        hrem_q [1:F];
	logic [SIX_W-1:0]        six_q  [1:F];
	logic [F-1:0]            hq_q   [1:F];
	logic [CB-1:0]           srem_q [1:F];
	logic [CB-1:0]           den_q  [1:F];
	logic [F-1:0]            sq_q   [1:F];
	logic                    full_q [1:F];
	logic [SUM_W-1:0]        sum_q  [1:F];
	logic                    gray_q [1:F];
	logic                    adv;

	// Whole pipeline moves together when the last stage is free or taken.
	assign adv      = !v_q[F] || out_ready;
	assign in_ready = adv;

	for (genvar k = 0; k < F; k++) begin : g_stage
		logic               v_in, full_in, gray_in, hbit, sbit;
		logic [SIX_W-1:0]   hrem_in, six_in, hrem_nx;
		logic [F-1:0]       hq_in, sq_in;
		logic [CB-1:0]      srem_in, den_in, srem_nx;
		logic [SUM_W-1:0]   sum_in;
		logic [SIX_W:0]     hsh;
		logic [CB:0]        ssh;

		if (k == 0) begin : g_src
			assign v_in    = in_valid;
			assign hrem_in = in_item.hue_num;
			assign six_in  = in_item.six;
			assign hq_in   = '0;
			assign srem_in = in_item.delta;
			assign den_in  = in_item.den;
			assign sq_in   = '0;
			assign full_in = in_item.sat_full;
			assign sum_in  = in_item.sum;
			assign gray_in = in_item.gray;
		end else begin : g_src
			assign v_in    = v_q[k];
			assign hrem_in = hrem_q[k];
			assign six_in  = six_q[k];
			assign hq_in   = hq_q[k];
			assign srem_in = srem_q[k];
			assign den_in  = den_q[k];
			assign sq_in   = sq_q[k];
			assign full_in = full_q[k];
			assign sum_in  = sum_q[k];
			assign gray_in = gray_q[k];
		end

		// One restoring step for each divider.
		always_comb begin
			hsh     = {hrem_in, 1'b0};
			hbit    = (hsh >= {1'b0, six_in});
			hrem_nx = hbit ? SIX_W'(hsh - {1'b0, six_in}) : hsh[SIX_W-1:0];
			ssh     = {srem_in, 1'b0};
			sbit    = (ssh >= {1'b0, den_in});
			srem_nx = sbit ? CB'(ssh - {1'b0, den_in}) : ssh[CB-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (adv) begin
				v_q[k+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				hrem_q[k+1] <= hrem_nx;
				six_q[k+1]  <= six_in;
				hq_q[k+1]   <= {hq_in[F-2:0], hbit};
				srem_q[k+1] <= srem_nx;
				den_q[k+1]  <= den_in;
				sq_q[k+1]   <= {sq_in[F-2:0], sbit};
				full_q[k+1] <= full_in;
				sum_q[k+1]  <= sum_in;
				gray_q[k+1] <= gray_in;
			end
		end
	end

	// Gray forces zeros; saturation of one clamps to all ones.
	assign out_valid     = v_q[F];
	assign hue           = gray_q[F] ? '0 : hq_q[F];
	assign saturation    = gray_q[F] ? '0 : (full_q[F] ? '1 : sq_q[F]);
	assign lightness_sum = sum_q[F];
	assign achromatic    = gray_q[F];

endmodule

// File: rtl/rgb_to_hsl_converter_core.sv
// Top level of the RGB to HSL converter: stream ports, front stage, queue and dividers.
//
// One item in, one item out. The slave channel takes one pixel per item in
// s_axis_tdata; the master channel returns hue, saturation and the lightness
// sum in m_axis_tdata, with the gray flag in m_axis_tuser.
// An accepted pixel passes the classify register, then the queue, then one divider stage
// per quotient bit (FRACTION_BITS stages, 16 with defaults) before its result is valid.
// Throughput is one item per cycle while the receiver does not stall; the divider
// pipeline retires one quotient bit per stage for both the hue and the saturation
// division.
// When the receiver stalls, the divider pipeline holds and the two-entry
// queue plus the classify stage keep taking items until they are full.
// Reset (arst_n low) empties every stage and the queue; items in flight are dropped,
// no item is produced across it, and there is no state beyond the items in flight.
module rgb_to_hsl_converter_core import r2h_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// red [7:0], green [15:8], blue [23:16]
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// hue [15:0], saturation [31:16], lightness_sum [40:32], zero fill above
	output logic [OUT_W-1:0] m_axis_tdata,
	// achromatic [0]
	output logic [0:0]       m_axis_tuser
);

	logic                     f_valid, f_ready, b_valid, b_ready;
	r2h_item_t                f_item, b_item;
	logic [FRACTION_BITS-1:0] hue, saturation;
	logic [SUM_W-1:0]         lightness_sum;
	logic                     achromatic;

	r2h_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.red       (s_axis_tdata[CHANNEL_BITS-1:0]),
		.green     (s_axis_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS]),
		.blue      (s_axis_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_item  (f_item)
	);

	r2h_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_item   (f_item),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_item  (b_item)
	);

	r2h_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (b_valid),
		.in_ready      (b_ready),
		.in_item       (b_item),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.hue           (hue),
		.saturation    (saturation),
		.lightness_sum (lightness_sum),
		.achromatic    (achromatic)
	);

	// Result packing, first field lowest.
	assign m_axis_tdata = OUT_W'({lightness_sum, saturation, hue});
	assign m_axis_tuser = achromatic;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the RGB to HSL converter core.
module tb_top import r2h_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FULL_CH = (1 << CHANNEL_BITS) - 1;
	localparam longint FRAC_MAX = (64'd1 << FRACTION_BITS) - 1;
	localparam int LAT_CYCLES = FRACTION_BITS + 8;
	localparam int N_RANDOM = 800;
	localparam longint CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] blue;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] red;
	} pixel_t;

	typedef struct {
		logic [FRACTION_BITS-1:0] hue;
		logic [FRACTION_BITS-1:0] saturation;
		logic [SUM_W-1:0]         lightness_sum;
		logic                     achromatic;
	} hsl_t;

	// One row of the directed table; known marks a hand-typed expectation.
	typedef struct {
		pixel_t px;
		bit     known;
		hsl_t   res;
	} pixel_row_t;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [0:0]       m_axis_tuser;

	hsl_t       hsl_pending[$];
	pixel_row_t pixel_rows[$];
	int         mismatch_count = 0;
	longint     cycle_count = 0;
	bit         rx_no_stall;

	rgb_to_hsl_converter_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Truncated num/den as a fraction, clamped to the largest code.
	function automatic longint frac_quot(longint num, longint den);
		longint q;
		q = (num << FRACTION_BITS) / den;
		return (q > FRAC_MAX) ? FRAC_MAX : q;
	endfunction

	// Predicted hue, saturation and lightness of one pixel.
	function automatic hsl_t hsl_of(pixel_t px);
		hsl_t   o;
		longint r, g, b, mx, mn, dl, sm, den, pos, neg;
		r = px.red;
		g = px.green;
		b = px.blue;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		dl = mx - mn;
		sm = mx + mn;
		o.lightness_sum = SUM_W'(sm);
		o.achromatic = (dl == 0);
		o.hue = '0;
		o.saturation = '0;
		if (dl != 0) begin
			den = (sm <= FULL_CH) ? sm : (2 * FULL_CH - sm);
			o.saturation = FRACTION_BITS'(frac_quot(dl, den));
			// Red wins ties, then green.
			if (r == mx) begin
				pos = g;
				neg = b;
			end else if (g == mx) begin
				pos = 2 * dl + b;
				neg = r;
			end else begin
				pos = 4 * dl + r;
				neg = g;
			end
			if (pos < neg) pos += 6 * dl;
			o.hue = FRACTION_BITS'(frac_quot(pos - neg, 6 * dl));
		end
		return o;
	endfunction

	function automatic pixel_row_t mk_row(int r, int g, int b);
		pixel_row_t row;
		row.px.red = CHANNEL_BITS'(r);
		row.px.green = CHANNEL_BITS'(g);
		row.px.blue = CHANNEL_BITS'(b);
		row.known = 1'b0;
		row.res = hsl_of(row.px);
		return row;
	endfunction

	function automatic pixel_row_t mk_known(int r, int g, int b, longint h, longint s,
			int l, bit a);
		pixel_row_t row;
		row = mk_row(r, g, b);
		row.known = 1'b1;
		row.res.hue = FRACTION_BITS'(h);
		row.res.saturation = FRACTION_BITS'(s);
		row.res.lightness_sum = SUM_W'(l);
		row.res.achromatic = a;
		return row;
	endfunction

	// Send one pixel, with random idle cycles unless told not to.
	task automatic send_pixel(pixel_t px, hsl_t res, bit may_idle);
		while (may_idle && $urandom_range(99) < 18) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_W'(px);
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		hsl_pending.push_back(res);
		@(negedge clk);
	endtask

	function automatic pixel_t rand_pixel();
		pixel_t px;
		int     k;
		px = pixel_t'(IN_W'($urandom));
		k = $urandom_range(9);
		// Bias toward ties, grays and extremes.
		case (k)
			0: px.green = px.red;
			1: px.blue = px.red;
			2: px.blue = px.green;
			3: begin
				px.green = px.red;
				px.blue = px.red;
			end
			4: px.red = CHANNEL_BITS'($urandom_range(1) ? FULL_CH : 0);
			5: px.blue = CHANNEL_BITS'($urandom_range(1) ? FULL_CH : 0);
			default: ;
		endcase
		return px;
	endfunction

	// Receiver: random stalls and comparison against the oldest expectation.
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_axis_tready <= rx_no_stall || ($urandom_range(99) >= 18);
		end
	end

	always @(posedge clk) begin
		hsl_t exp_res;
		hsl_t got;
		cycle_count <= cycle_count + 1;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.hue = m_axis_tdata[FRACTION_BITS-1:0];
			got.saturation = m_axis_tdata[2*FRACTION_BITS-1:FRACTION_BITS];
			got.lightness_sum = m_axis_tdata[2*FRACTION_BITS+SUM_W-1:2*FRACTION_BITS];
			got.achromatic = m_axis_tuser[0];
			if (hsl_pending.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result h=%0d s=%0d l=%0d a=%0d",
						got.hue, got.saturation, got.lightness_sum, got.achromatic);
			end else begin
				exp_res = hsl_pending.pop_front();
				if (got.hue !== exp_res.hue || got.saturation !== exp_res.saturation ||
						got.lightness_sum !== exp_res.lightness_sum ||
						got.achromatic !== exp_res.achromatic) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch exp h=%0d s=%0d l=%0d a=%0d got h=%0d s=%0d l=%0d a=%0d",
							exp_res.hue, exp_res.saturation, exp_res.lightness_sum,
							exp_res.achromatic, got.hue, got.saturation,
							got.lightness_sum, got.achromatic);
				end
			end
		end
	end

	// Watchdog on total run length.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("simulation failed");
		$finish;
	end

	// Stimulus.
	initial begin
		pixel_t px;
		int     drain;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		rx_no_stall = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table: grays, primaries, full saturation, ties, negative hue.
		pixel_rows.push_back(mk_known(0, 0, 0, 0, 0, 0, 1));
		pixel_rows.push_back(mk_known(255, 255, 255, 0, 0, 510, 1));
		pixel_rows.push_back(mk_known(128, 128, 128, 0, 0, 256, 1));
		pixel_rows.push_back(mk_known(255, 0, 0, 0, FRAC_MAX, 255, 0));
		pixel_rows.push_back(mk_known(0, 255, 0, 21845, FRAC_MAX, 255, 0));
		pixel_rows.push_back(mk_known(0, 0, 255, 43690, FRAC_MAX, 255, 0));
		pixel_rows.push_back(mk_known(255, 255, 0, 10922, FRAC_MAX, 255, 0));
		pixel_rows.push_back(mk_known(0, 255, 255, 32768, FRAC_MAX, 255, 0));
		pixel_rows.push_back(mk_known(255, 0, 255, 54613, FRAC_MAX, 255, 0));
		pixel_rows.push_back(mk_row(255, 0, 1));
		pixel_rows.push_back(mk_row(1, 0, 0));
		pixel_rows.push_back(mk_row(255, 254, 254));
		pixel_rows.push_back(mk_row(254, 255, 255));
		pixel_rows.push_back(mk_row(0, 1, 0));
		pixel_rows.push_back(mk_row(200, 100, 50));
		pixel_rows.push_back(mk_row(50, 200, 100));
		pixel_rows.push_back(mk_row(100, 50, 200));
		pixel_rows.push_back(mk_row(128, 127, 0));
		pixel_rows.push_back(mk_row(170, 85, 85));
		pixel_rows.push_back(mk_row(85, 170, 170));
		foreach (pixel_rows[i]) send_pixel(pixel_rows[i].px, pixel_rows[i].res, 1'b1);

		for (int n = 0; n < N_RANDOM; n++) begin
			px = rand_pixel();
			// A stretch with no idling on either side.
			rx_no_stall = (n >= 300 && n < 400);
			send_pixel(px, hsl_of(px), !rx_no_stall);
			// Sender holds off until everything is back.
			if (n == 500) begin
				s_axis_tvalid <= 1'b0;
				wait (hsl_pending.size() == 0);
				@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b0;

		drain = 0;
		while (hsl_pending.size() != 0) begin
			@(posedge clk);
			drain++;
			if (drain > 100000) break;
		end
		repeat (LAT_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && hsl_pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
